/* sv/phong_vertex_lighting_unit_defines.svh */
// Assertion macros shared by the vertex lighting RTL.
// Files that check their own logic include this header; it depends on nothing.
`ifndef PHONG_VERTEX_LIGHTING_UNIT_DEFINES_SVH
`define PHONG_VERTEX_LIGHTING_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PVL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PVL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pvl_pkg.sv */
// Shared widths, register codes and sideband types of the vertex lighting unit.
// Used by the interfaces and every module; depends on nothing.
`timescale 1ns / 1ps

package pvl_pkg;

    localparam int COMP_W  = 16;            // position and normal components
    localparam int CH_W    = 16;            // one colour channel
    localparam int REG_W   = 48;            // widest configuration register
    localparam int IDX_W   = 3;             // configuration register index
    localparam int SHIN_W  = 8;             // shininess exponent
    localparam int DIFF_W  = COMP_W + 1;    // light minus vertex
    localparam int SQ_W    = 34;            // squared distance
    localparam int DOT_W   = 35;            // raw dot product
    localparam int RAD_W   = SQ_W + 16;     // square root operand
    localparam int ROOT_W  = RAD_W / 2;     // square root result
    localparam int NUM_W   = DOT_W + 8;     // dividend width
    localparam int Q_W     = 16;            // quotient bits formed by the divider
    localparam int UNIT_W  = 15;            // Q1.14 value in [0, 1.0]
    localparam int PROD_W  = 2 * CH_W;      // light colour times material
    localparam int TERM_W  = PROD_W + UNIT_W;
    localparam int SUM_W   = TERM_W + 2;
    localparam int POW_STAGES = (2 ** SHIN_W) - 1;
    localparam logic [UNIT_W-1:0] ONE_Q14 = UNIT_W'(16384);

    typedef enum logic [IDX_W-1:0] {
        CFG_LIGHT_POS   = 3'd0,
        CFG_LIGHT_COLOR = 3'd1,
        CFG_MAT_AMB     = 3'd2,
        CFG_MAT_DIF     = 3'd3,
        CFG_MAT_SPE     = 3'd4,
        CFG_SHININESS   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DOT_W-1:0]  dot;
        logic signed [DIFF_W-1:0] dz;
        logic signed [COMP_W-1:0] nz;
        logic                     degen;
    } sqrt_side_t;

    typedef struct packed {
        logic                     dz_neg;
        logic signed [COMP_W-1:0] nz;
        logic                     degen;
    } div_side_t;

    typedef struct packed {
        logic [UNIT_W-1:0] d;
        logic              degen;
    } pow_side_t;

endpackage

/* sv/pvl_vertex_if.sv */
// Vertex input channel: valid/ready handshake with position and normal.
// Depends on pvl_pkg for the component width.
`timescale 1ns / 1ps

interface pvl_vertex_if
    import pvl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] pos_x;
    logic signed [COMP_W-1:0] pos_y;
    logic signed [COMP_W-1:0] pos_z;
    logic signed [COMP_W-1:0] normal_x;
    logic signed [COMP_W-1:0] normal_y;
    logic signed [COMP_W-1:0] normal_z;

    modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    output ready);
endinterface

/* sv/pvl_color_if.sv */
// Lit colour output channel: valid/ready handshake with RGB and degenerate flag.
// Depends on pvl_pkg for the channel width.
`timescale 1ns / 1ps

interface pvl_color_if
    import pvl_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            degenerate;

    modport source (output valid, red, green, blue, degenerate, input ready);
    modport sink   (input valid, red, green, blue, degenerate, output ready);
endinterface

/* sv/phong_vertex_lighting_unit.sv */
// Throughput: one vertex per cycle; the whole pipeline advances together and holds
// in place while the output item waits, so nothing is dropped or repeated.
// The 255 specular stages (one per possible shininess step) set the depth.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// register defaults: light at the origin, white light, black material, shininess one.
`timescale 1ns / 1ps

module phong_vertex_lighting_unit
    import pvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]  cfg_wdata,
    pvl_vertex_if.sink        vtx,
    pvl_color_if.source       col
);

`include "phong_vertex_lighting_unit_defines.svh"

    // ------------------------------------------------------------------
    // Configuration registers. Change only while the pipeline is empty; not enforced.
    // ------------------------------------------------------------------
    logic [REG_W-1:0]  light_pos_reg;
    logic [REG_W-1:0]  light_color_reg;
    logic [REG_W-1:0]  mat_amb_reg;
    logic [REG_W-1:0]  mat_dif_reg;
    logic [REG_W-1:0]  mat_spe_reg;
    logic [SHIN_W-1:0] shininess_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_pos_reg   <= '0;
            light_color_reg <= '1;
            mat_amb_reg     <= '0;
            mat_dif_reg     <= '0;
            mat_spe_reg     <= '0;
            shininess_reg   <= SHIN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIGHT_POS:   light_pos_reg   <= cfg_wdata;
                CFG_LIGHT_COLOR: light_color_reg <= cfg_wdata;
                CFG_MAT_AMB:     mat_amb_reg     <= cfg_wdata;
                CFG_MAT_DIF:     mat_dif_reg     <= cfg_wdata;
                CFG_MAT_SPE:     mat_spe_reg     <= cfg_wdata;
                CFG_SHININESS:   shininess_reg   <= cfg_wdata[SHIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Light colour times each material colour depends only on configuration, so it
    // is formed continuously and is settled long before any vertex needs it.
    logic [PROD_W-1:0] lc_amb_reg [3];
    logic [PROD_W-1:0] lc_dif_reg [3];
    logic [PROD_W-1:0] lc_spe_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            lc_amb_reg[k] <= light_color_reg[CH_W*k +: CH_W] * mat_amb_reg[CH_W*k +: CH_W];
            lc_dif_reg[k] <= light_color_reg[CH_W*k +: CH_W] * mat_dif_reg[CH_W*k +: CH_W];
            lc_spe_reg[k] <= light_color_reg[CH_W*k +: CH_W] * mat_spe_reg[CH_W*k +: CH_W];
        end
    end

    // ------------------------------------------------------------------
    // Global advance. The output register is the last stage; every stage moves
    // when it is empty or being taken, and all of them hold otherwise.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic en;

    assign en        = !out_valid_reg || col.ready;
    assign vtx.ready = en;

    // ------------------------------------------------------------------
    // Stage A: light-minus-vertex vector, its squares and its products with
    // the normal.
    // ------------------------------------------------------------------
    logic signed [COMP_W-1:0] pos_in [3];
    logic signed [COMP_W-1:0] nrm_in [3];
    logic signed [DIFF_W-1:0] diff   [3];
    logic signed [2*DIFF_W-1:0]        sq_prod  [3];
    logic signed [DIFF_W+COMP_W-1:0]   dot_prod [3];

    assign pos_in[0] = vtx.pos_x;
    assign pos_in[1] = vtx.pos_y;
    assign pos_in[2] = vtx.pos_z;
    assign nrm_in[0] = vtx.normal_x;
    assign nrm_in[1] = vtx.normal_y;
    assign nrm_in[2] = vtx.normal_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k]     = DIFF_W'($signed(light_pos_reg[COMP_W*k +: COMP_W]))
                        - DIFF_W'(pos_in[k]);
            sq_prod[k]  = diff[k] * diff[k];
            dot_prod[k] = diff[k] * nrm_in[k];
        end
    end

    logic                     va_reg;
    logic [SQ_W-1:0]          sqt_reg  [3];
    logic signed [DOT_W-1:0]  dott_reg [3];
    logic signed [DIFF_W-1:0] dza_reg;
    logic signed [COMP_W-1:0] nza_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= vtx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sqt_reg[k]  <= SQ_W'(sq_prod[k]);
                dott_reg[k] <= DOT_W'(dot_prod[k]);
            end
            dza_reg <= diff[2];
            nza_reg <= nrm_in[2];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: squared distance and dot product sums. A zero distance means
    // the light sits on the vertex, and only the ambient term survives.
    // ------------------------------------------------------------------
    logic               vb_reg;
    logic [SQ_W-1:0]    sq_next;
    logic [SQ_W-1:0]    sq_reg;
    sqrt_side_t         sideb_reg;

    assign sq_next = sqt_reg[0] + sqt_reg[1] + sqt_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg          <= sq_next;
            sideb_reg.dot   <= dott_reg[0] + dott_reg[1] + dott_reg[2];
            sideb_reg.dz    <= dza_reg;
            sideb_reg.nz    <= nza_reg;
            sideb_reg.degen <= (sq_next == '0);
        end
    end

    // ------------------------------------------------------------------
    // Length of the light vector in units of 2^-8 (25 stages).
    // ------------------------------------------------------------------
    logic              vq;
    logic [ROOT_W-1:0] len;
    sqrt_side_t        sideq;

    pvl_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .rad       ({sq_reg, 16'b0}),
        .in_side   (sideb_reg),
        .out_valid (vq),
        .root      (len),
        .out_side  (sideq)
    );

    // ------------------------------------------------------------------
    // Normalizing divides (17 stages): the diffuse factor from the positive
    // part of the dot product, and the magnitude of the light z component.
    // ------------------------------------------------------------------
    logic [1:0][NUM_W-1:0]  div_num;
    logic [DIFF_W-1:0]      dz_mag;
    div_side_t              div_side_in;
    logic                   vdv;
    logic [1:0][UNIT_W-1:0] quot;
    div_side_t              div_side_out;

    assign dz_mag    = sideq.dz[DIFF_W-1] ? DIFF_W'(-sideq.dz) : DIFF_W'(sideq.dz);
    assign div_num[0] = (sideq.dot > 0) ? (NUM_W'(sideq.dot) << 8) : '0;
    assign div_num[1] = NUM_W'(dz_mag) << 22;
    assign div_side_in.dz_neg = sideq.dz[DIFF_W-1];
    assign div_side_in.nz     = sideq.nz;
    assign div_side_in.degen  = sideq.degen;

    pvl_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vq),
        .num       (div_num),
        .den       (len),
        .in_side   (div_side_in),
        .out_valid (vdv),
        .quot      (quot),
        .out_side  (div_side_out)
    );

    // ------------------------------------------------------------------
    // Stage S1: d times the normal z component, and the signed light z.
    // ------------------------------------------------------------------
    logic                          v1_reg;
    logic [UNIT_W-1:0]             d_eff;
    logic signed [UNIT_W+COMP_W:0] dnz_reg;
    logic signed [DIFF_W-1:0]      lz_reg;
    pow_side_t                     side1_reg;

    assign d_eff = div_side_out.degen ? '0 : quot[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vdv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dnz_reg         <= $signed({1'b0, d_eff}) * div_side_out.nz;
            lz_reg          <= div_side_out.dz_neg ? -DIFF_W'(quot[1]) : DIFF_W'(quot[1]);
            side1_reg.d     <= d_eff;
            side1_reg.degen <= div_side_out.degen;
        end
    end

    // ------------------------------------------------------------------
    // Stage S2: specular base 2*d*nz - Lz, the halving rounded toward zero,
    // clamped to [0, 1.0].
    // ------------------------------------------------------------------
    localparam int HW = UNIT_W + COMP_W + 1;

    logic                     v2_reg;
    logic signed [HW-1:0]     dnz_biased;
    logic signed [HW-1:0]     half;
    logic signed [HW:0]       s_full;
    logic [UNIT_W-1:0]        s_reg;
    pow_side_t                side2_reg;

    assign dnz_biased = dnz_reg + (dnz_reg < 0 ? HW'(8191) : HW'(0));
    assign half       = dnz_biased >>> 13;
    assign s_full     = (HW+1)'(half) - (HW+1)'(lz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side1_reg;
            if (s_full < 0)
            begin
                s_reg <= '0;
            end
            else if (s_full > (HW+1)'(ONE_Q14))
            begin
                s_reg <= ONE_Q14;
            end
            else
            begin
                s_reg <= UNIT_W'(s_full);
            end
        end
    end

    // ------------------------------------------------------------------
    // Specular power chain (255 stages).
    // ------------------------------------------------------------------
    logic              vp;
    logic [UNIT_W-1:0] p_pow;
    pow_side_t         sidep;

    pvl_pow_pipe u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .shininess (shininess_reg),
        .in_valid  (v2_reg),
        .base      (s_reg),
        .in_side   (side2_reg),
        .out_valid (vp),
        .power     (p_pow),
        .out_side  (sidep)
    );

    // ------------------------------------------------------------------
    // Stage C1: diffuse and specular products per channel.
    // ------------------------------------------------------------------
    logic              vc_reg;
    logic [UNIT_W-1:0] p_eff;
    logic [TERM_W-1:0] td_reg [3];
    logic [TERM_W-1:0] ts_reg [3];
    logic              degc_reg;

    assign p_eff = sidep.degen ? '0 : p_pow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= vp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                td_reg[k] <= lc_dif_reg[k] * sidep.d;
                ts_reg[k] <= lc_spe_reg[k] * p_eff;
            end
            degc_reg <= sidep.degen;
        end
    end

    // ------------------------------------------------------------------
    // Stage C2 and output register: sum, scale to Q0.16 and saturate at 1.0.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] csum [3];
    logic [CH_W-1:0]  chan [3];
    logic [CH_W-1:0]  red_reg;
    logic [CH_W-1:0]  green_reg;
    logic [CH_W-1:0]  blue_reg;
    logic             degen_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            csum[k] = (SUM_W'(lc_amb_reg[k]) << 14) + SUM_W'(td_reg[k]) + SUM_W'(ts_reg[k]);
            if ((csum[k] >> 30) > SUM_W'(16'hFFFF))
            begin
                chan[k] = '1;
            end
            else
            begin
                chan[k] = csum[k][30 +: CH_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= chan[0];
            green_reg <= chan[1];
            blue_reg  <= chan[2];
            degen_reg <= degc_reg;
        end
    end

    assign col.valid      = out_valid_reg;
    assign col.red        = red_reg;
    assign col.green      = green_reg;
    assign col.blue       = blue_reg;
    assign col.degenerate = degen_reg;

    // ------------------------------------------------------------------
    // Checks on the arithmetic and the stall path.
    // ------------------------------------------------------------------
    `PVL_ASSERT_IMPL(a_len_floor, vq && !sideq.degen, len >= ROOT_W'(256),
                     "nonzero distance gave a length below one")
    `PVL_ASSERT_IMPL(a_base_clamped, v2_reg, s_reg <= ONE_Q14,
                     "specular base above one")
    `PVL_ASSERT_IMPL(a_diffuse_clamped, vdv, d_eff <= ONE_Q14,
                     "diffuse factor above one")
    `PVL_ASSERT_IMPL(a_stall_reaches_input, out_valid_reg && !col.ready,
                     !vtx.ready, "input taken while output held")

endmodule

/* sv/pvl_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on pvl_pkg for widths and the sideband type.
`timescale 1ns / 1ps

module pvl_sqrt_pipe
    import pvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  sqrt_side_t        in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output sqrt_side_t        out_side
);

    logic                     valid_reg [ROOT_W];
    logic [RAD_W:0]           rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]        root_reg  [ROOT_W];
    sqrt_side_t               side_reg  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic              valid_in;
        logic [RAD_W:0]    rem_in;
        logic [ROOT_W-1:0] root_in;
        sqrt_side_t        side_in;
        logic [RAD_W:0]    trial;

        if (j == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = {1'b0, rad};
            assign root_in  = '0;
            assign side_in  = in_side;
        end else begin : g_next
            assign valid_in = valid_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        // Growing the root by 2^B raises its square by 2*root*2^B + 4^B.
        assign trial = ((RAD_W+1)'(root_in) << (B + 1)) | ((RAD_W+1)'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_in;
                if (rem_in >= trial)
                begin
                    rem_reg[j]  <= rem_in - trial;
                    root_reg[j] <= root_in | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[j]  <= rem_in;
                    root_reg[j] <= root_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

/* sv/pvl_div_pipe.sv */
// Two-lane pipelined restoring divider sharing one divisor, results clamped to 1.0.
// Depends on pvl_pkg for widths and the sideband type.
`timescale 1ns / 1ps

module pvl_div_pipe
    import pvl_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [1:0][NUM_W-1:0]        num,
    input  logic [ROOT_W-1:0]            den,
    input  div_side_t                    in_side,
    output logic                         out_valid,
    output logic [1:0][UNIT_W-1:0]       quot,
    output div_side_t                    out_side
);

    localparam int CMP_W = NUM_W + 1;

    // Front stage: note quotients that cannot fit in Q_W bits.
    logic               valid0_reg;
    logic [1:0]         ovf0_reg;
    logic [1:0][NUM_W-1:0] rem0_reg;
    logic [ROOT_W-1:0]  den0_reg;
    div_side_t          side0_reg;

    logic               valid_reg [Q_W];
    logic [1:0]         ovf_reg   [Q_W];
    logic [1:0][NUM_W-1:0] rem_reg [Q_W];
    logic [1:0][Q_W-1:0] q_reg    [Q_W];
    logic [ROOT_W-1:0]  den_reg   [Q_W];
    div_side_t          side_reg  [Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (en)
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                ovf0_reg[l] <= CMP_W'(num[l]) >= (CMP_W'(den) << Q_W);
            end
            rem0_reg  <= num;
            den0_reg  <= den;
            side0_reg <= in_side;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int B = Q_W - 1 - j;
        logic                  valid_in;
        logic [1:0]            ovf_in;
        logic [1:0][NUM_W-1:0] rem_in;
        logic [1:0][Q_W-1:0]   q_in;
        logic [ROOT_W-1:0]     den_in;
        div_side_t             side_in;
        logic [CMP_W-1:0]      shifted;

        if (j == 0) begin : g_first
            assign valid_in = valid0_reg;
            assign ovf_in   = ovf0_reg;
            assign rem_in   = rem0_reg;
            assign q_in     = '0;
            assign den_in   = den0_reg;
            assign side_in  = side0_reg;
        end else begin : g_next
            assign valid_in = valid_reg[j-1];
            assign ovf_in   = ovf_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign q_in     = q_reg[j-1];
            assign den_in   = den_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        assign shifted = CMP_W'(den_in) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[j]  <= ovf_in;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
                for (int l = 0; l < 2; l++)
                begin
                    if (CMP_W'(rem_in[l]) >= shifted)
                    begin
                        rem_reg[j][l] <= rem_in[l] - NUM_W'(shifted);
                        q_reg[j][l]   <= q_in[l] | (Q_W'(1) << B);
                    end
                    else
                    begin
                        rem_reg[j][l] <= rem_in[l];
                        q_reg[j][l]   <= q_in[l];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (ovf_reg[Q_W-1][l] || (q_reg[Q_W-1][l] > Q_W'(ONE_Q14)))
            begin
                quot[l] = ONE_Q14;
            end
            else
            begin
                quot[l] = q_reg[Q_W-1][l][UNIT_W-1:0];
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

/* sv/pvl_pow_pipe.sv */
// Specular power: one truncating Q1.14 multiply per stage, skipped past the exponent.
// Depends on pvl_pkg for widths and the sideband type.
`timescale 1ns / 1ps

module pvl_pow_pipe
    import pvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [SHIN_W-1:0] shininess,
    input  logic              in_valid,
    input  logic [UNIT_W-1:0] base,
    input  pow_side_t         in_side,
    output logic              out_valid,
    output logic [UNIT_W-1:0] power,
    output pow_side_t         out_side
);

    logic              valid_reg [POW_STAGES];
    logic [UNIT_W-1:0] p_reg     [POW_STAGES];
    logic [UNIT_W-1:0] s_reg     [POW_STAGES];
    pow_side_t         side_reg  [POW_STAGES];

    for (genvar j = 0; j < POW_STAGES; j++) begin : g_stage
        logic                  valid_in;
        logic [UNIT_W-1:0]     p_in;
        logic [UNIT_W-1:0]     s_in;
        pow_side_t             side_in;
        logic [2*UNIT_W-1:0]   prod;

        if (j == 0) begin : g_first
            assign valid_in = in_valid;
            assign p_in     = ONE_Q14;
            assign s_in     = base;
            assign side_in  = in_side;
        end else begin : g_next
            assign valid_in = valid_reg[j-1];
            assign p_in     = p_reg[j-1];
            assign s_in     = s_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        assign prod = p_in * s_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[j]    <= s_in;
                side_reg[j] <= side_in;
                if (SHIN_W'(j) < shininess)
                begin
                    p_reg[j] <= UNIT_W'(prod >> 14);
                end
                else
                begin
                    p_reg[j] <= p_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[POW_STAGES-1];
    assign power     = p_reg[POW_STAGES-1];
    assign out_side  = side_reg[POW_STAGES-1];

endmodule
